### rtl/dcd_pkg.sv
// shared types, constants and calendar helpers for the day count to date block
// no dependencies
package dcd_pkg;

    localparam int unsigned DayW    = 16;
    localparam int unsigned SecW    = 17;
    localparam int unsigned UnitW   = 17;
    localparam int unsigned InDataW = 40;
    localparam int unsigned OutDataW = 40;

    localparam logic [DayW-1:0] LastDay    = 16'd50038;
    localparam logic [SecW-1:0] LastSecond = 17'd86399;

    localparam logic [UnitW-1:0] BlockDays      = 17'd1461;
    localparam logic [UnitW-1:0] BlockDaysShort = 17'd1460;
    localparam logic [UnitW-1:0] LeapYearDays   = 17'd366;
    localparam logic [UnitW-1:0] YearDays       = 17'd365;
    localparam logic [UnitW-1:0] HourSecs       = 17'd3600;
    localparam logic [UnitW-1:0] MinSecs        = 17'd60;

    // 2100 is offset 100: its four-year block has no leap day
    localparam logic [7:0] CenturyYear = 8'd100;
    localparam logic [3:0] December    = 4'd11;
    localparam logic [3:0] February    = 4'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BLOCK,
        S_YEAR,
        S_MONTH,
        S_HOUR,
        S_MIN,
        S_DONE
    } t_state;

    function automatic logic is_leap(input logic [7:0] year_off);
        return (year_off[1:0] == 2'b00) && (year_off != CenturyYear);
    endfunction

    // month index from 0, february given without the leap day
    function automatic logic [4:0] month_days(input logic [3:0] mon);
        logic [4:0] len;
        unique case (mon)
            4'd1:                      len = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

### rtl/day_count_to_calendar_date_top.sv
// day count since 2000-01-01 and second of day to calendar date and time of day
// single shared 17-bit subtract/compare unit stepped by a small sequencer
// depends on dcd_pkg
// an out-of-range beat goes straight to the done state; otherwise the sequencer
//   subtracts four-year blocks, then years, months, hours and minutes, one
//   subtraction per cycle through the shared unit, then loads the result
// throughput: one beat at a time; the next beat is taken once the sequencer is idle
// reset: synchronous, active low; clears the sequencer and the output valid
module day_count_to_calendar_date_top
    import dcd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // [15:0] day_count, [32:16] second_of_day, [39:33] zero
    input  logic [InDataW-1:0]  i_s_axis_tdata,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // [7:0] year_offset, [11:8] month, [16:12] day_of_month, [21:17] hour,
    // [27:22] minute, [33:28] second, [39:34] zero
    output logic [OutDataW-1:0] o_m_axis_tdata,
    // [0] range_error
    output logic                o_m_axis_tuser
);

    t_state r_state, n_state;

    logic [DayW-1:0] r_day, n_day;
    logic [SecW-1:0] r_sec, n_sec;
    logic [7:0]      r_year, n_year;
    logic [3:0]      r_mon, n_mon;
    logic [4:0]      r_hour, n_hour;
    logic [5:0]      r_min, n_min;
    logic            r_err, n_err;

    logic                r_out_valid;
    logic [OutDataW-1:0] r_out_data;
    logic                r_out_err;

    logic             in_beat;
    logic             out_free;
    logic [DayW-1:0]  in_day;
    logic [SecW-1:0]  in_sec;
    logic             in_bad;

    // shared subtract/compare unit
    logic             use_sec;
    logic [UnitW-1:0] sub_a, sub_b;
    logic [UnitW:0]   sub_diff;
    logic             sub_ge;
    logic             year_leap;
    logic             load_out;

    assign in_day  = i_s_axis_tdata[DayW-1:0];
    assign in_sec  = i_s_axis_tdata[DayW+SecW-1:DayW];
    assign in_bad  = (in_day > LastDay) || (in_sec > LastSecond);
    assign in_beat = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign year_leap = is_leap(r_year);

    assign o_s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        use_sec = (r_state == S_HOUR) || (r_state == S_MIN);
        unique case (r_state)
            S_BLOCK: sub_b = (r_year == CenturyYear) ? BlockDaysShort : BlockDays;
            S_YEAR:  sub_b = year_leap ? LeapYearDays : YearDays;
            S_MONTH: sub_b = ((r_mon == February) && year_leap) ? UnitW'(29)
                                                                 : UnitW'(month_days(r_mon));
            S_HOUR:  sub_b = HourSecs;
            S_MIN:   sub_b = MinSecs;
            default: sub_b = '0;
        endcase
        sub_a    = use_sec ? r_sec : {1'b0, r_day};
        sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
        sub_ge   = !sub_diff[UnitW];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_beat) n_state = in_bad ? S_DONE : S_BLOCK;
            S_BLOCK: if (!sub_ge) n_state = S_YEAR;
            S_YEAR:  if (!sub_ge) n_state = S_MONTH;
            S_MONTH: if (!sub_ge || r_mon == December) n_state = S_HOUR;
            S_HOUR:  if (!sub_ge) n_state = S_MIN;
            S_MIN:   if (!sub_ge) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath updates
    always_comb begin
        n_day  = r_day;
        n_sec  = r_sec;
        n_year = r_year;
        n_mon  = r_mon;
        n_hour = r_hour;
        n_min  = r_min;
        n_err  = r_err;
        load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_day  = in_day;
                    n_sec  = in_sec;
                    n_year = '0;
                    n_mon  = '0;
                    n_hour = '0;
                    n_min  = '0;
                    n_err  = in_bad;
                end
            end
            S_BLOCK: begin
                if (sub_ge) begin
                    n_day  = sub_diff[DayW-1:0];
                    n_year = r_year + 8'd4;
                end
            end
            S_YEAR: begin
                if (sub_ge) begin
                    n_day  = sub_diff[DayW-1:0];
                    n_year = r_year + 8'd1;
                end
            end
            S_MONTH: begin
                if (sub_ge && r_mon != December) begin
                    n_day = sub_diff[DayW-1:0];
                    n_mon = r_mon + 4'd1;
                end
            end
            S_HOUR: begin
                if (sub_ge) begin
                    n_sec  = sub_diff[SecW-1:0];
                    n_hour = r_hour + 5'd1;
                end
            end
            S_MIN: begin
                if (sub_ge) begin
                    n_sec = sub_diff[SecW-1:0];
                    n_min = r_min + 6'd1;
                end
            end
            S_DONE:  load_out = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out)
                r_out_valid <= 1'b1;
            else if (i_m_axis_tready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_day  <= n_day;
        r_sec  <= n_sec;
        r_year <= n_year;
        r_mon  <= n_mon;
        r_hour <= n_hour;
        r_min  <= n_min;
        r_err  <= n_err;
        if (load_out) begin
            r_out_err <= r_err;
            if (r_err)
                r_out_data <= '0;
            else
                r_out_data <= {6'd0, r_sec[5:0], r_min, r_hour,
                               r_day[4:0] + 5'd1, r_mon + 4'd1, r_year};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_err;

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_s_axis_tready)
        else $error("input ready while sequencer busy");

    a_beat_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> (r_state == S_BLOCK || r_state == S_DONE))
        else $error("accepted beat did not start the sequencer");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("range error result carries non-zero fields");

    a_fields_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |->
            (o_m_axis_tdata[11:8] != 4'd0 && o_m_axis_tdata[11:8] <= 4'd12 &&
             o_m_axis_tdata[16:12] != 5'd0 && o_m_axis_tdata[21:17] <= 5'd23 &&
             o_m_axis_tdata[27:22] <= 6'd59 && o_m_axis_tdata[7:0] <= 8'd136))
        else $error("result field out of calendar range");

endmodule
